### rtl/core/rtp_sender_header_dtmf_gen_top_assert.svh
// Assertion macros for the RTP header generator RTL, used by rsh_ser.
`ifndef RTP_SENDER_HEADER_DTMF_GEN_TOP_ASSERT_SVH
`define RTP_SENDER_HEADER_DTMF_GEN_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RSH_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define RSH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/rsh_pkg.sv
// Types, register codes and reset values for the RTP header generator.
package rsh_pkg;

    localparam int CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_INIT_SEQ   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_TS    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_ID  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AUDIO_PT   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TONE_PT    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TONE_EN    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_SMP  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 4'd7;

    localparam logic [6:0]  RST_TONE_PT     = 7'd101;
    localparam logic [12:0] RST_FRAME_SMP   = 13'd160;
    localparam logic [17:0] RST_SAMPLE_RATE = 18'd8000;

    localparam logic [15:0] DUR_MAX = 16'hFFFF;

    typedef struct packed {
        logic [15:0] initial_sequence;
        logic [31:0] initial_timestamp;
        logic [31:0] source_id;
        logic [6:0]  audio_payload_type;
        logic [6:0]  tone_payload_type;
        logic        tone_enable;
        logic [12:0] frame_samples;
        logic [17:0] sample_rate;
    } t_cfg;

    typedef struct packed {
        logic       digit_request;
        logic [3:0] digit;
    } t_in;

    typedef struct packed {
        logic [31:0] header_word;
        logic        is_tone;
        logic        last_word;
    } t_out;

    // One frame's packet: up to four words, word 0 first.
    typedef struct packed {
        logic [3:0][31:0] words;
        logic             tone;
    } t_pkt;

endpackage

### rtl/core/rsh_engine.sv
// Frame state engine: sequence, timestamp and telephone-event state, packet build.
module rsh_engine (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rsh_pkg::t_cfg   i_cfg,
    input  logic            i_cfg_load,
    input  logic [15:0]     i_load_seq,
    input  logic [31:0]     i_load_ts,
    input  logic            i_accept,
    input  rsh_pkg::t_in    i_item,
    output rsh_pkg::t_pkt   o_pkt
);

    logic [15:0] r_seq, n_seq;
    logic [31:0] r_ts, n_ts;
    logic        r_active;
    logic [3:0]  r_code;
    logic [15:0] r_dur;

    logic        start;
    logic        act;
    logic [15:0] base;
    logic [16:0] dur_sum;
    logic [15:0] dur;
    logic [18:0] dur_x5;
    logic        end_flag;
    logic [3:0]  code;
    logic [31:0] ts_tone;

    always_comb begin
        start    = i_item.digit_request & i_cfg.tone_enable;
        act      = start | r_active;
        base     = start ? 16'd0 : r_dur;
        dur_sum  = {1'b0, base} + {4'b0, i_cfg.frame_samples};
        dur      = dur_sum[16] ? rsh_pkg::DUR_MAX : dur_sum[15:0];
        dur_x5   = {1'b0, dur, 2'b0} + {3'b0, dur};
        end_flag = dur_x5 >= {1'b0, i_cfg.sample_rate};
        code     = start ? i_item.digit : r_code;
        n_seq    = r_seq + 16'd1;
        n_ts     = r_ts + {19'b0, i_cfg.frame_samples};
        // (ts + step) - (base + step) == ts - base; duration cannot saturate
        // before the end test fires.
        ts_tone  = r_ts - {16'b0, base};
    end

    always_comb begin
        o_pkt.tone = act;
        if (act) begin
            o_pkt.words[0] = {1'b1, 8'b0, i_cfg.tone_payload_type, n_seq};
            o_pkt.words[1] = ts_tone;
            o_pkt.words[2] = i_cfg.source_id;
            o_pkt.words[3] = {4'b0, code, end_flag, 7'b0, dur};
        end else begin
            o_pkt.words[0] = {1'b1, 8'b0, i_cfg.audio_payload_type, n_seq};
            o_pkt.words[1] = n_ts;
            o_pkt.words[2] = i_cfg.source_id;
            o_pkt.words[3] = 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq    <= 16'd0;
            r_ts     <= 32'd0;
            r_active <= 1'b0;
            r_code   <= 4'd0;
            r_dur    <= 16'd0;
        end else if (i_cfg_load) begin
            r_seq <= i_load_seq;
            r_ts  <= i_load_ts;
        end else if (i_accept) begin
            r_seq <= n_seq;
            r_ts  <= n_ts;
            if (act) begin
                r_active <= ~end_flag;
                r_code   <= code;
                r_dur    <= dur;
            end
        end
    end

endmodule

### rtl/core/rsh_ser.sv
// Word serializer: holds one packet and emits it a word per transaction.
`include "rtp_sender_header_dtmf_gen_top_assert.svh"

module rsh_ser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rsh_pkg::t_pkt   i_pkt,
    input  logic            i_load,
    output logic            o_load_ok,
    output logic            o_valid,
    output rsh_pkg::t_out   o_data,
    input  logic            i_stall
);

    logic               r_valid;
    rsh_pkg::t_out      r_out;
    logic [2:0][31:0]   r_q;
    logic [1:0]         r_left;
    logic               r_tone;
    logic               taken;

    assign taken     = r_valid & ~i_stall;
    assign o_load_ok = ~r_valid | (taken & (r_left == 2'd0));
    assign o_valid   = r_valid;
    assign o_data    = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_left  <= 2'd0;
        end else if (i_load) begin
            r_valid             <= 1'b1;
            r_out.header_word   <= i_pkt.words[0];
            r_out.is_tone       <= i_pkt.tone;
            r_out.last_word     <= 1'b0;
            r_tone              <= i_pkt.tone;
            r_q[0]              <= i_pkt.words[1];
            r_q[1]              <= i_pkt.words[2];
            r_q[2]              <= i_pkt.words[3];
            r_left              <= i_pkt.tone ? 2'd3 : 2'd2;
        end else if (taken) begin
            if (r_left != 2'd0) begin
                r_out.header_word <= r_q[0];
                r_out.is_tone     <= r_tone;
                r_out.last_word   <= (r_left == 2'd1);
                r_q[0]            <= r_q[1];
                r_q[1]            <= r_q[2];
                r_left            <= r_left - 2'd1;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    `RSH_ASSERT_NOW(a_left_needs_valid, i_clk, i_rst_n, r_left != 2'd0, r_valid,
        "words queued without a valid output word")
    `RSH_ASSERT_NOW(a_last_drains, i_clk, i_rst_n, r_valid && r_out.last_word,
        r_left == 2'd0, "last word shown with words still queued")
    `RSH_ASSERT_NEXT(a_done_clears, i_clk, i_rst_n,
        taken && r_left == 2'd0 && !i_load, !r_valid,
        "output stays valid after the packet drained")

endmodule

### rtl/core/rtp_sender_header_dtmf_gen_top.sv
// Top level of the RTP header generator with telephone events.
//
// Usage:
//  - Input channel (i_in_valid / o_in_stall / i_in_data): one transaction per
//    audio frame tick, optionally requesting a DTMF digit.
//  - Output channel (o_out_valid / i_out_stall / o_out_data): the packet
//    header words of each tick, first word first. An audio tick gives three
//    words, a tick with an active telephone event gives four; last_word marks
//    the final word and is_tone tells the two apart.
//  - Config channel (i_cfg_valid / o_cfg_ready, always ready): writes one
//    register; any write to a known register reloads the sequence and
//    timestamp counters from their initial values. Unknown indexes are
//    dropped. Write only while the block is idle.
//  - Timing: the first word of a tick is valid the cycle after the tick is
//    taken. Throughput is set by the output word serializer moving one word
//    per cycle while i_out_stall is low; the next tick is taken in the same
//    cycle as the last word of the previous one is taken.
//  - Stall: i_out_stall freezes the output word; once the serializer is full
//    o_in_stall rises and holds the input side off.
//  - Reset (synchronous, active low): registers return to defaults, counters
//    clear, no event is active, the output channel goes empty.
module rtp_sender_header_dtmf_gen_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  rsh_pkg::t_in                      i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output rsh_pkg::t_out                     o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rsh_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [31:0]                       i_cfg_data
);

    rsh_pkg::t_cfg r_cfg, n_cfg;
    rsh_pkg::t_pkt pkt;
    logic          cfg_wr;
    logic          cfg_hit;
    logic          load_ok;
    logic          accept;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid & o_cfg_ready;
    assign o_in_stall  = ~load_ok;
    assign accept      = i_in_valid & load_ok;

    // Register file decode; the counters reload from the post-write values.
    always_comb begin
        n_cfg   = r_cfg;
        cfg_hit = 1'b0;
        if (cfg_wr) begin
            cfg_hit = 1'b1;
            unique case (i_cfg_index)
                rsh_pkg::CFG_INIT_SEQ:    n_cfg.initial_sequence   = i_cfg_data[15:0];
                rsh_pkg::CFG_INIT_TS:     n_cfg.initial_timestamp  = i_cfg_data;
                rsh_pkg::CFG_SOURCE_ID:   n_cfg.source_id          = i_cfg_data;
                rsh_pkg::CFG_AUDIO_PT:    n_cfg.audio_payload_type = i_cfg_data[6:0];
                rsh_pkg::CFG_TONE_PT:     n_cfg.tone_payload_type  = i_cfg_data[6:0];
                rsh_pkg::CFG_TONE_EN:     n_cfg.tone_enable        = i_cfg_data[0];
                rsh_pkg::CFG_FRAME_SMP:   n_cfg.frame_samples      = i_cfg_data[12:0];
                rsh_pkg::CFG_SAMPLE_RATE: n_cfg.sample_rate        = i_cfg_data[17:0];
                default:                  cfg_hit                  = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.initial_sequence   <= 16'd0;
            r_cfg.initial_timestamp  <= 32'd0;
            r_cfg.source_id          <= 32'd0;
            r_cfg.audio_payload_type <= 7'd0;
            r_cfg.tone_payload_type  <= rsh_pkg::RST_TONE_PT;
            r_cfg.tone_enable        <= 1'b0;
            r_cfg.frame_samples      <= rsh_pkg::RST_FRAME_SMP;
            r_cfg.sample_rate        <= rsh_pkg::RST_SAMPLE_RATE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Per-tick state and packet build, one pass per accepted tick.
    rsh_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_cfg_load (cfg_hit),
        .i_load_seq (n_cfg.initial_sequence),
        .i_load_ts  (n_cfg.initial_timestamp),
        .i_accept   (accept),
        .i_item     (i_in_data),
        .o_pkt      (pkt)
    );

    // Packet holding register and word-at-a-time output.
    rsh_ser u_ser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pkt     (pkt),
        .i_load    (accept),
        .o_load_ok (load_ok),
        .o_valid   (o_out_valid),
        .o_data    (o_out_data),
        .i_stall   (i_out_stall)
    );

endmodule

### test/rsh_frame_checker.sv
// Scoreboard for the RTP header generator: predicts each tick's header words and checks them.
`timescale 1ns / 100ps

module rsh_frame_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  rsh_pkg::t_in                 i_in_data,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  rsh_pkg::t_out                i_out_data,
    input  logic                         i_cfg_valid,
    input  logic                         i_cfg_ready,
    input  logic [rsh_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                  i_cfg_data,
    output int                           o_fail_count,
    output int                           o_pending
);
    import rsh_pkg::*;

    localparam logic [31:0] RTP_V2      = 32'h8000_0000;
    localparam logic [31:0] EVT_END     = 32'h0080_0000;
    localparam int unsigned EVT_LEN_DIV = 5;    // event lasts a fifth of a second

    t_cfg        regs;
    logic [15:0] seq_ctr;
    logic [31:0] ts_ctr;
    logic        evt_on;
    logic [3:0]  evt_digit;
    logic [15:0] evt_dur;
    t_out        hdr_words_q[$];

    function automatic t_out hdr_word(logic [31:0] w, logic tone, logic last);
        t_out o;
        o.header_word = w;
        o.is_tone     = tone;
        o.last_word   = last;
        return o;
    endfunction

    function automatic void reset_model();
        regs.initial_sequence   = '0;
        regs.initial_timestamp  = '0;
        regs.source_id          = '0;
        regs.audio_payload_type = '0;
        regs.tone_payload_type  = RST_TONE_PT;
        regs.tone_enable        = 1'b0;
        regs.frame_samples      = RST_FRAME_SMP;
        regs.sample_rate        = RST_SAMPLE_RATE;
        seq_ctr   = '0;
        ts_ctr    = '0;
        evt_on    = 1'b0;
        evt_digit = '0;
        evt_dur   = '0;
    endfunction

    // Known registers reload both counters; the event state survives.
    function automatic void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        logic known;
        known = 1'b1;
        case (idx)
            CFG_INIT_SEQ:    regs.initial_sequence   = data[15:0];
            CFG_INIT_TS:     regs.initial_timestamp  = data;
            CFG_SOURCE_ID:   regs.source_id          = data;
            CFG_AUDIO_PT:    regs.audio_payload_type = data[6:0];
            CFG_TONE_PT:     regs.tone_payload_type  = data[6:0];
            CFG_TONE_EN:     regs.tone_enable        = data[0];
            CFG_FRAME_SMP:   regs.frame_samples      = data[12:0];
            CFG_SAMPLE_RATE: regs.sample_rate        = data[17:0];
            default:         known = 1'b0;
        endcase
        if (known) begin
            seq_ctr = regs.initial_sequence;
            ts_ctr  = regs.initial_timestamp;
        end
    endfunction

    function automatic void predict_frame(t_in tick);
        logic [16:0] dur_sum;
        logic [31:0] end_flag;
        seq_ctr = seq_ctr + 16'd1;
        ts_ctr  = ts_ctr + 32'(regs.frame_samples);
        if (tick.digit_request && regs.tone_enable) begin
            evt_on    = 1'b1;
            evt_digit = tick.digit;
            evt_dur   = '0;
        end
        if (evt_on) begin
            dur_sum = {1'b0, evt_dur} + 17'(regs.frame_samples);
            if (dur_sum > {1'b0, DUR_MAX})
                dur_sum = {1'b0, DUR_MAX};
            evt_dur  = dur_sum[15:0];
            end_flag = '0;
            if (int'(evt_dur) * EVT_LEN_DIV >= int'(regs.sample_rate)) begin
                end_flag = EVT_END;
                evt_on   = 1'b0;
            end
            hdr_words_q.push_back(hdr_word(RTP_V2 | {9'd0, regs.tone_payload_type, seq_ctr},
                                           1'b1, 1'b0));
            hdr_words_q.push_back(hdr_word(ts_ctr - {16'd0, evt_dur}, 1'b1, 1'b0));
            hdr_words_q.push_back(hdr_word(regs.source_id, 1'b1, 1'b0));
            hdr_words_q.push_back(hdr_word({4'd0, evt_digit, 24'd0} | end_flag | {16'd0, evt_dur},
                                           1'b1, 1'b1));
        end else begin
            hdr_words_q.push_back(hdr_word(RTP_V2 | {9'd0, regs.audio_payload_type, seq_ctr},
                                           1'b0, 1'b0));
            hdr_words_q.push_back(hdr_word(ts_ctr, 1'b0, 1'b0));
            hdr_words_q.push_back(hdr_word(regs.source_id, 1'b0, 1'b1));
        end
    endfunction

    function automatic void check_word(t_out got);
        t_out want;
        if (hdr_words_q.size() == 0) begin
            $error("header word %08h arrived with none pending", got.header_word);
            o_fail_count++;
            return;
        end
        want = hdr_words_q.pop_front();
        if (got.header_word !== want.header_word) begin
            $error("header_word: expected %08h, got %08h", want.header_word, got.header_word);
            o_fail_count++;
        end
        if (got.is_tone !== want.is_tone) begin
            $error("is_tone: expected %0b, got %0b", want.is_tone, got.is_tone);
            o_fail_count++;
        end
        if (got.last_word !== want.last_word) begin
            $error("last_word: expected %0b, got %0b", want.last_word, got.last_word);
            o_fail_count++;
        end
    endfunction

    // A word leaving at this edge belongs to an earlier tick, so check before predicting.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
            hdr_words_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall)
                check_word(i_out_data);
            if (i_in_valid && !i_in_stall)
                predict_frame(i_in_data);
            if (i_cfg_valid && i_cfg_ready)
                write_reg(i_cfg_index, i_cfg_data);
        end
        o_pending = hdr_words_q.size();
    end

endmodule

### test/rtp_sender_header_dtmf_gen_top_tb.sv
// Testbench top for the RTP header generator: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module rtp_sender_header_dtmf_gen_top_tb;
    import rsh_pkg::*;

    localparam int LIMIT_CYCLES   = 500_000;  // many times the slowest legal run
    localparam int RX_HOLD_CYCLES = 200;      // long output back-pressure stretch
    localparam int SETTLE_CYCLES  = 8;        // quiet time once the last word is out
    localparam int RAND_PHASES    = 12;
    localparam int PHASE_TICKS    = 30;
    localparam int REQ_PCT        = 15;       // share of ticks carrying a digit request

    // Indexes with no register behind them; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 4'd8;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 4'd15;

    // Every block input has a known value from time zero.
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    t_in                  i_in_data   = '0;
    logic                 i_out_stall = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]          i_cfg_data  = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    t_out                 o_out_data;
    logic                 o_cfg_ready;

    int fail_count;
    int pending_words;
    int cycle_cnt = 0;

    // Flow-control knobs shared by the sender, the receiver and the phase sequencer.
    bit snd_rush    = 1'b0;   // sender offers back to back
    bit rx_rush     = 1'b0;   // receiver never stalls
    bit rx_hold_req = 1'b0;   // receiver holds off for RX_HOLD_CYCLES

    rtp_sender_header_dtmf_gen_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    rsh_frame_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_words)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic t_in mk_tick(logic req, logic [3:0] dig);
        t_in t;
        t.digit_request = req;
        t.digit         = dig;
        return t;
    endfunction

    function automatic t_in rand_tick();
        t_in t;
        t.digit_request = ($urandom_range(0, 99) < REQ_PCT);
        t.digit         = 4'($urandom_range(0, 15));
        return t;
    endfunction

    // Random half the time, otherwise all-zeros or all-ones.
    function automatic logic [31:0] pick32();
        logic [31:0] v;
        case ($urandom_range(0, 3))
            0:       v = '0;
            1:       v = '1;
            default: v = $urandom();
        endcase
        return v;
    endfunction

    // One frame-tick transaction. valid stays up after acceptance so that a
    // zero gap keeps the channel busy; the next call lowers it if it idles.
    task automatic send_tick(input t_in tick);
        int unsigned gap;
        gap = snd_rush ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= tick;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Stop offering, then wait until every predicted word has been checked.
    // The extra edge lets the checker book the last accepted tick first.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending_words == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write; only issued while the block is idle. valid is dropped
    // between writes so back-to-back writes never collide within a time step.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // New register set for a random phase. Sample rate mostly tracks frame
    // size so events end within a handful of ticks; extremes show up too.
    // Upper data bits carry noise that the block must drop.
    task automatic rand_config();
        logic [31:0] fs;
        logic [31:0] sr;
        logic [31:0] w;
        case ($urandom_range(0, 7))
            0:       fs = 32'd1;
            1:       fs = 32'd4096;
            2:       fs = 32'd8191;
            3:       fs = 32'd0;
            default: fs = $urandom_range(1, 400);
        endcase
        case ($urandom_range(0, 7))
            0:       sr = 32'd0;
            1:       sr = 32'd2;
            2:       sr = 32'h3_FFFF;
            default: sr = fs * 5 * $urandom_range(1, 6) - $urandom_range(0, 3);
        endcase
        if ($urandom_range(0, 1)) cfg_write(CFG_INIT_SEQ, pick32());
        if ($urandom_range(0, 1)) cfg_write(CFG_INIT_TS, pick32());
        if ($urandom_range(0, 1)) cfg_write(CFG_SOURCE_ID, $urandom());
        if ($urandom_range(0, 1)) cfg_write(CFG_AUDIO_PT, pick32());
        if ($urandom_range(0, 1)) cfg_write(CFG_TONE_PT, pick32());
        w = $urandom();
        cfg_write(CFG_TONE_EN, {w[31:1], 1'($urandom_range(0, 4) != 0)});
        w = $urandom();
        cfg_write(CFG_FRAME_SMP, {w[31:13], fs[12:0]});
        w = $urandom();
        cfg_write(CFG_SAMPLE_RATE, {w[31:18], sr[17:0]});
    endtask

    // Output side: per word, a random stall (none under rx_rush), then take it.
    // On request, one long hold so the block backs up into its input channel.
    initial begin : sink
        int unsigned hold;
        @(posedge i_rst_n);
        forever begin
            if (rx_hold_req) begin
                i_out_stall <= 1'b1;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                rx_hold_req = 1'b0;
            end
            hold = rx_rush ? 0 : $urandom_range(0, 15);
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
        end
    end

    initial begin : stimulus
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values: audio headers only; a request while disabled is ignored.
        send_tick(mk_tick(1'b0, 4'd0));
        send_tick(mk_tick(1'b1, 4'd5));

        // Counters near wrap, payload types at their limits (upper data bits
        // must be dropped), events enabled, three ticks per event.
        wait_idle();
        cfg_write(CFG_INIT_SEQ, 32'hABCD_FFFE);
        cfg_write(CFG_INIT_TS, 32'hFFFF_FF00);
        cfg_write(CFG_SOURCE_ID, 32'hDEAD_BEEF);
        cfg_write(CFG_AUDIO_PT, 32'hFFFF_FFFF);
        cfg_write(CFG_TONE_PT, 32'hFFFF_FF80);
        cfg_write(CFG_TONE_EN, 32'd1);
        cfg_write(CFG_FRAME_SMP, 32'd160);
        cfg_write(CFG_SAMPLE_RATE, 32'd2000);
        send_tick(mk_tick(1'b0, 4'd0));     // sequence wraps to zero next
        send_tick(mk_tick(1'b1, 4'd0));     // event starts, timestamp wraps
        send_tick(mk_tick(1'b0, 4'd0));
        send_tick(mk_tick(1'b1, 4'd15));    // new digit mid-event restarts it
        send_tick(mk_tick(1'b0, 4'd0));
        send_tick(mk_tick(1'b0, 4'd0));     // end bit set here
        send_tick(mk_tick(1'b0, 4'd0));     // back to audio

        // Disabling mid-event lets the running event play out.
        send_tick(mk_tick(1'b1, 4'd9));
        wait_idle();
        cfg_write(CFG_TONE_EN, 32'd0);
        send_tick(mk_tick(1'b0, 4'd0));
        send_tick(mk_tick(1'b0, 4'd0));
        send_tick(mk_tick(1'b1, 4'd3));     // ignored, events disabled

        // Unused indexes: no register change and no counter reload.
        wait_idle();
        cfg_write(CFG_UNUSED_LO, 32'hFFFF_FFFF);
        cfg_write(CFG_UNUSED_HI, 32'h5A5A_A5A5);
        send_tick(mk_tick(1'b0, 4'd0));

        // Zero frame size with zero rate: the event ends on its first packet.
        wait_idle();
        cfg_write(CFG_TONE_EN, 32'd1);
        cfg_write(CFG_FRAME_SMP, 32'd0);
        cfg_write(CFG_SAMPLE_RATE, 32'd0);
        send_tick(mk_tick(1'b1, 4'd10));

        // Zero frame size with the top rate: duration never grows, the event
        // hangs until the frame size goes to its maximum.
        wait_idle();
        cfg_write(CFG_SAMPLE_RATE, 32'hFFFF_FFFF);
        send_tick(mk_tick(1'b1, 4'd7));
        send_tick(mk_tick(1'b0, 4'd0));
        wait_idle();
        cfg_write(CFG_FRAME_SMP, 32'hFFFF_FFFF);
        repeat (7) send_tick(mk_tick(1'b0, 4'd0));

        // Random phases, each under a fresh register set and flow-control mix.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_idle();
            rand_config();
            snd_rush = ($urandom_range(0, 3) == 0);
            rx_rush  = ($urandom_range(0, 3) == 0);
            if (ph == 3) begin
                // Receiver stalls long while the sender keeps pushing.
                rx_hold_req = 1'b1;
                snd_rush    = 1'b1;
            end
            for (int k = 0; k < PHASE_TICKS; k++) begin
                send_tick(rand_tick());
                if ($urandom_range(0, 39) == 0)
                    wait_idle();
            end
        end

        wait_idle();
        if (fail_count == 0 && pending_words == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
